### src/kfs_pkg.sv
// Package for the keyframe search and ratio block: field widths, codes,
// payload structs and the command/status structs between controller and datapath.
// No dependencies.
package kfs_pkg;

  // Default values of the top-level parameters.
  localparam int MAX_KEYS_DEF   = 256;
  localparam int TIME_SHIFT_DEF = 3;
  localparam int RATIO_BITS_DEF = 16;

  // Fixed field widths.
  localparam int KEY_SLOT_W   = 8;
  localparam int KEY_TIME_W   = 15;
  localparam int SAMPLE_W     = 18;
  localparam int COUNT_W      = 9;
  localparam int RATIO_W      = 16;
  localparam int MODE_W       = 2;
  localparam int CACHE_W      = 8;
  localparam int KEY_WORD_W   = KEY_TIME_W + 1;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 18;

  // Item actions.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Result modes.
  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INTERP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_EMPTY  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION  = 2'd1;

  // Header table read address selects.
  localparam logic [2:0] RD_CACHE   = 3'd0;
  localparam logic [2:0] RD_MIDCALC = 3'd1;
  localparam logic [2:0] RD_MID1    = 3'd2;
  localparam logic [2:0] RD_K1      = 3'd3;
  localparam logic [2:0] RD_K       = 3'd4;

  typedef struct packed {
    logic                  action;
    logic [KEY_SLOT_W-1:0] key_slot;
    logic [KEY_TIME_W-1:0] key_time_units;
    logic                  key_is_step;
    logic [SAMPLE_W-1:0]   sample_time_ms;
  } kfs_item_t;

  typedef struct packed {
    logic [KEY_SLOT_W-1:0] start_key;
    logic [KEY_SLOT_W-1:0] next_key;
    logic [RATIO_W-1:0]    blend_ratio;
    logic [MODE_W-1:0]     sample_mode;
  } kfs_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } kfs_cfg_t;

  typedef struct packed {
    logic              key_wr;
    logic              take;
    logic              bs_init;
    logic              set_mid;
    logic              hi_mid;
    logic              lo_mid1;
    logic              k_cache;
    logic              k_mid;
    logic              k_inc;
    logic              t0_load;
    logic              div_init;
    logic              div_step;
    logic              res_set;
    logic [MODE_W-1:0] res_mode;
    logic              rd_en;
    logic [2:0]        rd_sel;
    logic              out_load;
  } kfs_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic n_one;
    logic cache_oob;
    logic units_lt_rd;
    logic units_gt_rd;
    logic lo_lt_hi;
    logic mid1_lt_hi;
    logic k1_lt_n;
    logic interp_ok;
    logic div_last;
  } kfs_status_t;

endpackage

### src/kfs_if.sv
// Handshake channel interfaces of the keyframe search and ratio block.
// Depends on kfs_pkg for the payload structs.
interface kfs_item_if import kfs_pkg::*; ();
  logic      valid;
  logic      ready;
  kfs_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kfs_result_if import kfs_pkg::*; ();
  logic        valid;
  logic        ready;
  kfs_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kfs_cfg_if import kfs_pkg::*; ();
  logic     valid;
  logic     ready;
  kfs_cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/keyframe_search_and_ratio.sv
// Keyframe search and blend ratio: one sample item is worked at a time. A header
// load is written to the table as it is taken. A sample is taken, its key count is
// checked and, when the cached index is in range, that key's header is read and
// compared. A miss then runs a binary search; each probe reads the middle key and,
// when needed, the key after it. The forward walk reads and compares the following
// key for each key stepped over. Then the start header and, when there is one, the next
// header are fetched. Interpolate mode runs the one-bit-a-cycle divider for RATIO_BITS
// quotient bits, and the result is then loaded into the result register. The single
// read port of the header table, read once per step with registered data, sets the
// search pace. Empty and single-key samples go from the key count check straight to the
// result. Any sample also waits while the result register still holds an untaken result.
// The result register lets the next item be taken while a result still waits for its
// transfer.
// Depends on kfs_pkg, kfs_if, kfs_ctrl and kfs_dp.
module keyframe_search_and_ratio import kfs_pkg::*; #(
  parameter int MAX_KEYS   = MAX_KEYS_DEF,
  parameter int TIME_SHIFT = TIME_SHIFT_DEF,
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  kfs_item_if.sink     item,
  kfs_result_if.source result,
  kfs_cfg_if.sink      cfg
);

  kfs_cmd_t    cmd;
  kfs_status_t st;

  assign cfg.ready = 1'b1;

  kfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_action(item.data.action),
    .item_ready (item.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .st         (st),
    .cmd        (cmd)
  );

  kfs_dp #(
    .MAX_KEYS  (MAX_KEYS),
    .TIME_SHIFT(TIME_SHIFT),
    .RATIO_BITS(RATIO_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item_data  (item.data),
    .cfg_wr     (cfg.valid && cfg.ready),
    .cfg_data   (cfg.data),
    .st         (st),
    .result_data(result.data)
  );

endmodule

### src/kfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/kfs_ctrl.sv
// Controller of the keyframe search: takes header loads and sequences the cache check,
// binary search, forward walk, header fetch, serial division and result transfer.
// Depends on kfs_pkg for the command and status structs.
module kfs_ctrl import kfs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_action,
  output logic        item_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  kfs_status_t st,
  output kfs_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_CACHE    = 4'd2;
  localparam logic [3:0] S_BS_TEST  = 4'd3;
  localparam logic [3:0] S_BS_MID   = 4'd4;
  localparam logic [3:0] S_BS_MID1  = 4'd5;
  localparam logic [3:0] S_WALK     = 4'd6;
  localparam logic [3:0] S_WALK_CMP = 4'd7;
  localparam logic [3:0] S_FETCH0   = 4'd8;
  localparam logic [3:0] S_FETCH1   = 4'd9;
  localparam logic [3:0] S_DIV      = 4'd10;
  localparam logic [3:0] S_FINISH   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    item_ready = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          if (item_action == ACT_LOAD) begin
            cmd.key_wr = 1'b1;
          end else begin
            cmd.take   = 1'b1;
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (st.n_zero) begin
          cmd.res_set  = 1'b1;
          cmd.res_mode = MODE_EMPTY;
          state_next   = S_FINISH;
        end else if (st.n_one) begin
          cmd.res_set  = 1'b1;
          cmd.res_mode = MODE_SINGLE;
          state_next   = S_FINISH;
        end else if (st.cache_oob) begin
          cmd.bs_init = 1'b1;
          state_next  = S_BS_TEST;
        end else begin
          cmd.k_cache = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_CACHE;
          state_next  = S_CACHE;
        end
      end
      S_CACHE: begin
        if (st.units_lt_rd) begin
          cmd.bs_init = 1'b1;
          state_next  = S_BS_TEST;
        end else begin
          state_next = S_WALK;
        end
      end
      S_BS_TEST: begin
        if (st.lo_lt_hi) begin
          cmd.set_mid = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_MIDCALC;
          state_next  = S_BS_MID;
        end else begin
          cmd.k_mid  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_BS_MID: begin
        if (st.units_lt_rd) begin
          cmd.hi_mid = 1'b1;
          state_next = S_BS_TEST;
        end else if (st.mid1_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID1;
          state_next = S_BS_MID1;
        end else begin
          cmd.k_mid  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_BS_MID1: begin
        if (st.units_gt_rd) begin
          cmd.lo_mid1 = 1'b1;
          state_next  = S_BS_TEST;
        end else begin
          cmd.k_mid  = 1'b1;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        cmd.rd_en = 1'b1;
        if (st.k1_lt_n) begin
          cmd.rd_sel = RD_K1;
          state_next = S_WALK_CMP;
        end else begin
          cmd.rd_sel = RD_K;
          state_next = S_FETCH0;
        end
      end
      S_WALK_CMP: begin
        if (!st.units_lt_rd) begin
          cmd.k_inc  = 1'b1;
          state_next = S_WALK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_K;
          state_next = S_FETCH0;
        end
      end
      S_FETCH0: begin
        cmd.t0_load = 1'b1;
        if (st.k1_lt_n) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_K1;
          state_next = S_FETCH1;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_mode = MODE_HOLD;
          state_next   = S_FINISH;
        end
      end
      S_FETCH1: begin
        if (st.interp_ok) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_mode = MODE_HOLD;
          state_next   = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          cmd.res_set  = 1'b1;
          cmd.res_mode = MODE_INTERP;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        // The result register is free once its previous transfer completes.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### src/kfs_dp.sv
// Datapath of the keyframe search: configuration registers, header table,
// search registers, restoring divider and result register.
// Depends on kfs_pkg and kfs_ram.
module kfs_dp import kfs_pkg::*; #(
  parameter int MAX_KEYS   = MAX_KEYS_DEF,
  parameter int TIME_SHIFT = TIME_SHIFT_DEF,
  parameter int RATIO_BITS = RATIO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  kfs_cmd_t    cmd,
  input  kfs_item_t   item_data,
  input  logic        cfg_wr,
  input  kfs_cfg_t    cfg_data,
  output kfs_status_t st,
  output kfs_result_t result_data
);

  localparam int IW   = $clog2(MAX_KEYS);
  localparam int TW   = KEY_TIME_W + TIME_SHIFT;
  localparam int DW   = (TW > SAMPLE_W) ? TW : SAMPLE_W;
  localparam int QCW  = $clog2(RATIO_BITS);

  logic [COUNT_W-1:0]  key_count;
  logic [SAMPLE_W-1:0] duration_ms;
  logic [CACHE_W-1:0]  cache;

  logic [SAMPLE_W-1:0] t_cl;
  logic [SAMPLE_W-1:0] units;
  logic [COUNT_W-1:0]  n;
  logic [COUNT_W-1:0]  lo;
  logic [COUNT_W-1:0]  hi;
  logic [COUNT_W-1:0]  mid;
  logic [COUNT_W-1:0]  k;
  logic [TW-1:0]       t0;
  logic                step0;
  logic [DW-1:0]       rem;
  logic [DW-1:0]       den;
  logic [RATIO_BITS-1:0] q;
  logic [QCW-1:0]      qcnt;
  logic [KEY_SLOT_W-1:0] res_start;
  logic [KEY_SLOT_W-1:0] res_next;
  logic [MODE_W-1:0]   res_mode;

  logic [SAMPLE_W-1:0] t_clamp;
  logic [COUNT_W-1:0]  n_clamp;
  logic [COUNT_W-1:0]  mid_calc;
  logic [COUNT_W:0]    mid_p1;
  logic [COUNT_W:0]    k_p1;
  logic [COUNT_W-1:0]  raddr9;
  logic [31:0]         raddr32;
  logic [31:0]         waddr32;
  logic [31:0]         q32;
  logic                slot_ok;
  logic [KEY_WORD_W-1:0] rdata;
  logic [KEY_TIME_W-1:0] rd_time;
  logic [DW-1:0]       t_ext;
  logic [DW-1:0]       t0_ext;
  logic [DW-1:0]       t1_ext;
  logic [DW:0]         rem_sh;
  logic                rem_ge;

  assign t_clamp = (item_data.sample_time_ms > duration_ms) ? duration_ms
                                                             : item_data.sample_time_ms;
  assign n_clamp = (32'(key_count) > MAX_KEYS) ? COUNT_W'(MAX_KEYS) : key_count;

  assign mid_calc = lo + ((hi - lo) >> 1);
  assign mid_p1   = {1'b0, mid} + 1'b1;
  assign k_p1     = {1'b0, k} + 1'b1;

  always_comb begin
    case (cmd.rd_sel)
      RD_CACHE:   raddr9 = COUNT_W'(cache);
      RD_MIDCALC: raddr9 = mid_calc;
      RD_MID1:    raddr9 = mid_p1[COUNT_W-1:0];
      RD_K1:      raddr9 = k_p1[COUNT_W-1:0];
      RD_K:       raddr9 = k;
      default:    raddr9 = k;
    endcase
  end

  assign raddr32 = 32'(raddr9);
  assign waddr32 = 32'(item_data.key_slot);
  assign slot_ok = waddr32 < MAX_KEYS;

  kfs_ram #(
    .WIDTH(KEY_WORD_W),
    .DEPTH(MAX_KEYS)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (cmd.key_wr && slot_ok),
    .waddr(waddr32[IW-1:0]),
    .wdata({item_data.key_time_units, item_data.key_is_step}),
    .re   (cmd.rd_en),
    .raddr(raddr32[IW-1:0]),
    .rdata(rdata)
  );

  assign rd_time = rdata[KEY_WORD_W-1:1];

  assign t_ext  = DW'(t_cl);
  assign t0_ext = DW'(t0);
  assign t1_ext = DW'(TW'(rd_time) << TIME_SHIFT);

  assign rem_sh = {rem, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den};

  always_comb begin
    st.n_zero      = (n == '0);
    st.n_one       = (n == COUNT_W'(1));
    st.cache_oob   = COUNT_W'(cache) >= n;
    st.units_lt_rd = units < SAMPLE_W'(rd_time);
    st.units_gt_rd = units > SAMPLE_W'(rd_time);
    st.lo_lt_hi    = lo < hi;
    st.mid1_lt_hi  = mid_p1 < {1'b0, hi};
    st.k1_lt_n     = k_p1 < {1'b0, n};
    // Interpolation needs a smooth start key, a later next key and the time between them.
    st.interp_ok   = (t_ext >= t0_ext) && !step0 && (t1_ext > t0_ext) && (t_ext < t1_ext);
    st.div_last    = (qcnt == QCW'(RATIO_BITS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= '0;
      duration_ms <= '0;
      cache       <= '0;
    end else begin
      if (cfg_wr) begin
        if (cfg_data.index == CFG_KEY_COUNT) begin
          key_count <= cfg_data.value[COUNT_W-1:0];
        end else if (cfg_data.index == CFG_DURATION) begin
          duration_ms <= cfg_data.value[SAMPLE_W-1:0];
        end
      end
      if (cmd.res_set && (cmd.res_mode == MODE_HOLD || cmd.res_mode == MODE_INTERP)) begin
        cache <= k[CACHE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      t_cl  <= t_clamp;
      units <= t_clamp >> TIME_SHIFT;
      n     <= n_clamp;
    end
    if (cmd.bs_init) begin
      lo  <= '0;
      hi  <= n;
      mid <= '0;
    end
    if (cmd.set_mid) begin
      mid <= mid_calc;
    end
    if (cmd.hi_mid) begin
      hi <= mid;
    end
    if (cmd.lo_mid1) begin
      lo <= mid_p1[COUNT_W-1:0];
    end
    if (cmd.k_cache) begin
      k <= COUNT_W'(cache);
    end else if (cmd.k_mid) begin
      k <= mid;
    end else if (cmd.k_inc) begin
      k <= k_p1[COUNT_W-1:0];
    end
    if (cmd.t0_load) begin
      t0    <= TW'(rd_time) << TIME_SHIFT;
      step0 <= rdata[0];
    end
    if (cmd.div_init) begin
      rem  <= t_ext - t0_ext;
      den  <= t1_ext - t0_ext;
      q    <= '0;
      qcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? DW'(rem_sh - {1'b0, den}) : DW'(rem_sh);
      q    <= {q[RATIO_BITS-2:0], rem_ge};
      qcnt <= qcnt + 1'b1;
    end
    if (cmd.res_set) begin
      res_mode <= cmd.res_mode;
      if (cmd.res_mode == MODE_HOLD || cmd.res_mode == MODE_INTERP) begin
        res_start <= k[KEY_SLOT_W-1:0];
        res_next  <= k_p1[KEY_SLOT_W-1:0];
      end else begin
        res_start <= '0;
        res_next  <= '0;
      end
    end
    if (cmd.out_load) begin
      result_data.start_key   <= res_start;
      result_data.next_key    <= res_next;
      result_data.blend_ratio <= (res_mode == MODE_INTERP) ? q32[RATIO_W-1:0] : '0;
      result_data.sample_mode <= res_mode;
    end
  end

  assign q32 = 32'(q);

endmodule

### src/kfs_checker.sv
// Port-level checks of the keyframe search and ratio block, bound to its top level.
// Depends on kfs_pkg.
module kfs_checker import kfs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input kfs_result_t result_data
);

  // No result appears straight after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A pending result stays offered until it is taken.
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result withdrawn before transfer");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(result_data))
    else $error("result payload changed while stalled");

  // Neither a load nor a sample can produce a result in the cycle after its transfer.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && !result_valid) |=> !result_valid)
    else $error("result appeared one cycle after an input transfer");

endmodule

bind keyframe_search_and_ratio kfs_checker u_kfs_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .result_data (result.data)
);

### verif/tb_keyframe_search_and_ratio.sv
`timescale 1ns / 1ps
// Testbench for keyframe_search_and_ratio: header loads, samples and register writes under
// random flow control, with every result checked against a predictor kept in this file.
// Depends on kfs_pkg, the kfs_if channel interfaces and the block itself.
module tb_keyframe_search_and_ratio;
  import kfs_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 80;
  localparam int STALL_LIMIT   = 4000;
  localparam int DUR_MAX       = (1 << SAMPLE_W) - 1;
  localparam int TIME_MAX      = (1 << KEY_TIME_W) - 1;

  // Register indexes that the block has no register behind.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  logic clk;
  logic rst;

  kfs_item_if   item_ch ();
  kfs_result_if res_ch ();
  kfs_cfg_if    cfg_ch ();

  keyframe_search_and_ratio u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // Predicted state of the block.
  logic [KEY_TIME_W-1:0] hdr_time [MAX_KEYS_DEF];
  logic                  hdr_step [MAX_KEYS_DEF];
  logic [CACHE_W-1:0]    cached_key  = '0;
  logic [COUNT_W-1:0]    key_count_r = '0;
  logic [SAMPLE_W-1:0]   duration_r  = '0;
  kfs_result_t           pending_results [$];

  bit failed      = 1'b0;
  bit gaps_on     = 1'b1;
  bit rx_throttle = 1'b1;
  bit hold_off    = 1'b0;
  int burst_left  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Start key search: cached index first, binary search when the cache is out of range or
  // lies past the time, then a forward walk over keys that are already due.
  function automatic int find_start(logic [KEY_TIME_W-1:0] units, int n);
    int k, lo, hi, mid;
    bit searching;
    k = cached_key;
    if (k >= n || units < hdr_time[k]) begin
      lo = 0;
      hi = n;
      mid = 0;
      searching = 1'b1;
      while (searching && lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (units < hdr_time[mid]) hi = mid;
        else if (mid + 1 < hi && units > hdr_time[mid + 1]) lo = mid + 1;
        else searching = 1'b0;
      end
      k = mid;
    end
    while (k + 1 < n && units >= hdr_time[k + 1]) k++;
    return k;
  endfunction

  function automatic kfs_result_t sample_outcome(logic [SAMPLE_W-1:0] t_req);
    kfs_result_t r;
    int n, k;
    logic [SAMPLE_W-1:0] t, t0, t1;
    longint unsigned span_num;
    r = '0;
    n = (key_count_r > MAX_KEYS_DEF) ? MAX_KEYS_DEF : int'(key_count_r);
    t = (t_req > duration_r) ? duration_r : t_req;
    if (n == 0) r.sample_mode = MODE_EMPTY;
    else if (n == 1) r.sample_mode = MODE_SINGLE;
    else begin
      k = find_start(KEY_TIME_W'(t >> TIME_SHIFT_DEF), n);
      cached_key = CACHE_W'(k);
      t0 = SAMPLE_W'(hdr_time[k]) << TIME_SHIFT_DEF;
      r.start_key = KEY_SLOT_W'(k);
      r.next_key = KEY_SLOT_W'(k + 1);
      r.sample_mode = MODE_HOLD;
      if (t >= t0 && k + 1 < n && !hdr_step[k]) begin
        t1 = SAMPLE_W'(hdr_time[k + 1]) << TIME_SHIFT_DEF;
        if (t1 > t0 && t < t1) begin
          span_num = longint'(t - t0) << RATIO_BITS_DEF;
          r.blend_ratio = RATIO_W'(span_num / longint'(t1 - t0));
          r.sample_mode = MODE_INTERP;
        end
      end
    end
    return r;
  endfunction

  function automatic kfs_item_t load_item(int slot, int units, bit step);
    kfs_item_t it;
    it.action = ACT_LOAD;
    it.key_slot = KEY_SLOT_W'(slot);
    it.key_time_units = KEY_TIME_W'(units);
    it.key_is_step = step;
    it.sample_time_ms = SAMPLE_W'($urandom);
    return it;
  endfunction

  function automatic kfs_item_t sample_item(int t_ms);
    kfs_item_t it;
    it.action = ACT_SAMPLE;
    it.key_slot = KEY_SLOT_W'($urandom);
    it.key_time_units = KEY_TIME_W'($urandom);
    it.key_is_step = 1'($urandom);
    it.sample_time_ms = SAMPLE_W'(t_ms);
    return it;
  endfunction

  // Offers one item and updates the predictor at the edge of its transfer.
  task automatic send_item(kfs_item_t it);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    @(posedge clk);
    while (item_ch.ready !== 1'b1) @(posedge clk);
    if (it.action == ACT_SAMPLE) begin
      pending_results.push_back(sample_outcome(it.sample_time_ms));
    end else begin
      hdr_time[it.key_slot] = it.key_time_units;
      hdr_step[it.key_slot] = it.key_is_step;
    end
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        item_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    kfs_cfg_t w;
    w.index = idx;
    w.value = CFG_DATA_W'(value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= w;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    if (idx == CFG_KEY_COUNT) key_count_r = w.value[COUNT_W-1:0];
    else if (idx == CFG_DURATION) duration_r = w.value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits for every expected result, then lets a trailing load or sample finish.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes a run of headers with non-decreasing times, some of them equal.
  task automatic load_sorted(int first, int count, int base, int max_gap);
    int units;
    units = base;
    for (int s = first; s < first + count; s++) begin
      send_item(load_item(s, units, $urandom_range(0, 5) == 0));
      units += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, max_gap);
      if (units > TIME_MAX) units = TIME_MAX;
    end
  endtask

  task automatic test_empty_and_single();
    // Straight after reset there are no keys and the duration is zero.
    send_item(sample_item(DUR_MAX));
    drain();
    write_reg(CFG_DURATION, DUR_MAX);
    send_item(sample_item(0));
    send_item(load_item(0, 5, 1'b0));
    drain();
    write_reg(CFG_KEY_COUNT, 1);
    send_item(sample_item(0));
    send_item(sample_item(DUR_MAX));
    drain();
  endtask

  task automatic test_small_table();
    send_item(load_item(0, 3, 1'b0));
    send_item(load_item(1, 10, 1'b0));
    send_item(load_item(2, 10, 1'b1));
    send_item(load_item(3, TIME_MAX, 1'b1));
    drain();
    write_reg(CFG_KEY_COUNT, 4);
    send_item(sample_item(0));        // before the first key
    send_item(sample_item(50));       // between keys 0 and 1
    send_item(sample_item(79));
    send_item(sample_item(80));       // walks onto the step key
    send_item(sample_item(DUR_MAX));  // last key
    send_item(sample_item(100));      // cache past the time, so a fresh search
    drain();
    write_reg(CFG_SPARE_2, $urandom);
    write_reg(CFG_SPARE_3, $urandom);
    write_reg(CFG_KEY_COUNT, 2);
    write_reg(CFG_DURATION, 1000);
    send_item(sample_item(DUR_MAX));  // clamped to the duration
    send_item(sample_item(40));
    drain();
    write_reg(CFG_DURATION, 0);
    send_item(sample_item($urandom_range(0, DUR_MAX)));
    drain();
  endtask

  task automatic test_fill_table();
    load_sorted(0, MAX_KEYS_DEF, $urandom_range(0, 3), 127);
    drain();
  endtask

  task automatic test_random_phases();
    int n, eff, dur, last_ms, upper, hi_ms, play_ms, pick, slot;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: n = 2;
        1: n = MAX_KEYS_DEF;
        2: n = (1 << COUNT_W) - 1;
        3: n = MAX_KEYS_DEF - 1;
        default: begin
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(3, MAX_KEYS_DEF)
                                          : $urandom_range(2, 24);
        end
      endcase
      eff = (n > MAX_KEYS_DEF) ? MAX_KEYS_DEF : n;
      // One phase in four runs with no idling on either side.
      gaps_on = (p % 4) != 2;
      rx_throttle = (p % 4) != 2;
      if (n <= 24) load_sorted(0, n, $urandom_range(0, 3000), $urandom_range(1, 400));
      last_ms = int'(hdr_time[eff - 1]) << TIME_SHIFT_DEF;
      if (p == 1) dur = DUR_MAX;
      else if (p == 6) dur = 0;
      else dur = last_ms + $urandom_range(0, 4000);
      if (dur > DUR_MAX) dur = DUR_MAX;
      hi_ms = (dur + 64 > DUR_MAX) ? DUR_MAX : dur + 64;
      drain();
      upper = $urandom_range(0, 1) ? $urandom_range(0, 511) : 0;
      write_reg(CFG_KEY_COUNT, (upper << COUNT_W) | n);
      write_reg(CFG_DURATION, dur);
      play_ms = 0;
      for (int i = 0; i < 20; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          // Playback moving forward, which mostly hits the cached key.
          play_ms += $urandom_range(0, 40);
          if (play_ms > hi_ms) play_ms = 0;
          send_item(sample_item(play_ms));
        end else if (pick < 70) begin
          send_item(sample_item($urandom_range(0, hi_ms)));
        end else if (pick < 85) begin
          send_item(sample_item($urandom_range(0, DUR_MAX)));
        end else if (pick < 93) begin
          slot = $urandom_range(0, eff - 1);
          send_item(load_item(slot, hdr_time[slot], ~hdr_step[slot]));
        end else begin
          // Noise: any slot, any time, so the order of the table may break.
          send_item(load_item($urandom_range(0, 255), $urandom_range(0, TIME_MAX),
                              $urandom_range(0, 1)));
        end
      end
      drain();
    end
    gaps_on = 1'b1;
    rx_throttle = 1'b1;
  endtask

  // The receiver holds off for a long stretch while samples keep coming.
  task automatic test_backpressure();
    write_reg(CFG_KEY_COUNT, MAX_KEYS_DEF);
    write_reg(CFG_DURATION, DUR_MAX);
    gaps_on = 1'b0;
    hold_off = 1'b1;
    repeat (12) send_item(sample_item($urandom_range(0, DUR_MAX)));
    drain();
    gaps_on = 1'b1;
  endtask

  initial begin : result_sink
    int beat;
    beat = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      beat++;
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
        res_ch.ready <= 1'b1;
      end else if (!rx_throttle) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ((beat % 23) < 15) && ($urandom_range(0, 5) != 0);
      end
    end
  end

  function automatic void compare_field(string field, logic [RATIO_W-1:0] want,
                                        logic [RATIO_W-1:0] got);
    if (want !== got) begin
      failed = 1'b1;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    kfs_result_t want, got;
    if (rst === 1'b0 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = res_ch.data;
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected result: start %0d next %0d ratio %0d mode %0d", $time,
                 got.start_key, got.next_key, got.blend_ratio, got.sample_mode);
      end else begin
        want = pending_results.pop_front();
        compare_field("start_key", want.start_key, got.start_key);
        compare_field("next_key", want.next_key, got.next_key);
        compare_field("blend_ratio", want.blend_ratio, got.blend_ratio);
        compare_field("sample_mode", want.sample_mode, got.sample_mode);
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if (rst !== 1'b0 || (item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) stuck = 0;
      else stuck++;
    end
    $display("tb_keyframe_search_and_ratio: errors");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_single();
    test_small_table();
    test_fill_table();
    test_random_phases();
    test_backpressure();
    drain();
    if (!failed && pending_results.size() == 0) begin
      $display("tb_keyframe_search_and_ratio: clean");
    end else begin
      $display("tb_keyframe_search_and_ratio: errors");
    end
    $finish;
  end

endmodule

### keyframe_search_and_ratio.f
src/kfs_pkg.sv
src/kfs_if.sv
src/kfs_ram.sv
src/kfs_ctrl.sv
src/kfs_dp.sv
src/keyframe_search_and_ratio.sv
src/kfs_checker.sv
verif/tb_keyframe_search_and_ratio.sv
